### sv/rtts_pkg.sv
// Shared types, codes and constants of the retransmit sender.
package rtts_pkg;

  localparam int unsigned TIME_W    = 26;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned ATT_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 26;

  localparam logic [ATT_W-1:0]  RST_MAX_RETRIES = ATT_W'(7);
  localparam logic [TIME_W-1:0] RST_MIN_TIMEOUT = TIME_W'(10000);
  localparam logic [TIME_W-1:0] RST_MAX_TIMEOUT = TIME_W'(999999);
  localparam logic [TIME_W-1:0] RST_SPREAD      = TIME_W'(250);
  localparam logic [TIME_W-1:0] RST_ACK_WAIT    = TIME_W'(10000);
  localparam logic [ATT_W-1:0]  ATT_SAT         = '1;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_ERROR   = 2'd3
  } rtts_mode_e;

  typedef enum logic [1:0] {
    ACT_IGNORE   = 2'd0,
    ACT_TRANSMIT = 2'd1,
    ACT_DELIVER  = 2'd2,
    ACT_FAIL     = 2'd3
  } rtts_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RETRIES = 2'd0,
    CFG_MIN_TIMEOUT = 2'd1,
    CFG_MAX_TIMEOUT = 2'd2,
    CFG_UNUSED      = 2'd3
  } rtts_cfg_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] ack_id;
    logic            ack_from_target;
    logic [TIME_W-1:0] rtt_us;
  } rtts_in_t;

  typedef struct packed {
    rtts_action_e      action;
    logic [ID_W-1:0]   message_id;
    logic [TIME_W-1:0] wait_time;
    logic [ATT_W-1:0]  attempt_count;
    logic [TIME_W-1:0] rtt_average;
    logic [TIME_W-1:0] rtt_deviation;
    logic [CNT_W-1:0]  sent_total;
    logic [CNT_W-1:0]  resent_total;
    logic [CNT_W-1:0]  failed_total;
    logic              was_resent;
  } rtts_out_t;

  // estimator inputs and outputs
  typedef struct packed {
    logic [TIME_W-1:0] srtt;
    logic [TIME_W-1:0] spread;
    logic [TIME_W-1:0] sample;
    logic [TIME_W-1:0] min_timeout;
    logic [TIME_W-1:0] max_timeout;
  } rtts_est_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] srtt;
    logic [TIME_W-1:0] spread;
    logic [TIME_W-1:0] ack_wait;
  } rtts_est_out_t;

endpackage

### sv/rtts_estimator.sv
// Smoothed RTT / deviation update and clamped timeout for one ack sample.
module rtts_estimator (
  input  rtts_pkg::rtts_est_in_t  est_i,
  output rtts_pkg::rtts_est_out_t est_o
);
  import rtts_pkg::*;

  logic signed [TIME_W:0]   delta;
  logic signed [TIME_W:0]   srtt_sum;
  logic        [TIME_W:0]   mag;
  logic signed [TIME_W+1:0] dev_diff;
  logic signed [TIME_W+1:0] dev_sum;
  logic        [TIME_W-1:0] srtt_new;
  logic        [TIME_W-1:0] dev_new;
  logic        [TIME_W+2:0] wait_raw;
  logic        [TIME_W-1:0] wait_cap;

  always_comb begin
    delta    = signed'({1'b0, est_i.sample}) - signed'({1'b0, est_i.srtt});
    // gain 1/8, arithmetic shift floors toward minus infinity
    srtt_sum = signed'({1'b0, est_i.srtt}) + (delta >>> 3);
    srtt_new = srtt_sum[TIME_W-1:0];
    mag      = delta[TIME_W] ? unsigned'(-delta) : unsigned'(delta);
    // gain 1/4 on the deviation
    dev_diff = signed'({1'b0, mag}) - signed'({2'b00, est_i.spread});
    dev_sum  = signed'({2'b00, est_i.spread}) + (dev_diff >>> 2);
    dev_new  = dev_sum[TIME_W-1:0];
    wait_raw = {3'b000, srtt_new} + {1'b0, dev_new, 2'b00};
    // upper clamp first, then the lower one wins
    if (wait_raw > {3'b000, est_i.max_timeout}) begin
      wait_cap = est_i.max_timeout;
    end else begin
      wait_cap = wait_raw[TIME_W-1:0];
    end
    if (wait_cap < est_i.min_timeout) begin
      wait_cap = est_i.min_timeout;
    end
    est_o.srtt     = srtt_new;
    est_o.spread   = dev_new;
    est_o.ack_wait = wait_cap;
  end

endmodule

### sv/rtt_retransmit_sender_unit.sv
// Top level of the retransmit sender: event register, state update, result register.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------
//  in      | in  | in_valid_i / in_stall_o | in_data_i  (rtts_in_t)
//  out     | out | out_valid_o / out_stall_i | out_data_o (rtts_out_t)
//  cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// An accepted item sits in the event register, then moves into the result register,
// where its result becomes valid. One item per cycle sustained while out_stall_i is
// low; the rate is set by the single state update done on that move.
// Reset (rst_ni low, async) restores the state and config defaults and empties
// both stages. A stalled result holds the result register and, once the event
// register is full too, raises in_stall_o.
module rtt_retransmit_sender_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rtts_pkg::rtts_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rtts_pkg::rtts_out_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [rtts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rtts_pkg::CFG_W-1:0]    cfg_data_i
);
  import rtts_pkg::*;

  // configuration
  logic [ATT_W-1:0]  max_retries_q;
  logic [TIME_W-1:0] min_timeout_q, max_timeout_q;

  // event register and result register
  logic      ev_valid_q;
  rtts_in_t  ev_q;
  logic      out_valid_q;
  rtts_out_t out_q;
  logic      advance;

  // sender state
  logic [TIME_W-1:0] srtt_q, srtt_d;
  logic [TIME_W-1:0] spread_q, spread_d;
  logic [TIME_W-1:0] wait_q, wait_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [ATT_W-1:0]  att_q, att_d;
  logic              busy_q, busy_d;
  logic              resent_q, resent_d;
  logic [CNT_W-1:0]  sent_cnt_q, sent_cnt_d;
  logic [CNT_W-1:0]  resend_cnt_q, resend_cnt_d;
  logic [CNT_W-1:0]  fail_cnt_q, fail_cnt_d;
  rtts_action_e      action;

  rtts_est_in_t  est_in;
  rtts_est_out_t est_out;
  logic [TIME_W:0] wait_dbl;

  // result register frees up when empty or taken this cycle
  assign advance     = ev_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = ev_valid_q && out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q <= RST_MAX_RETRIES;
      min_timeout_q <= RST_MIN_TIMEOUT;
      max_timeout_q <= RST_MAX_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (rtts_cfg_e'(cfg_idx_i))
        CFG_MAX_RETRIES: max_retries_q <= cfg_data_i[ATT_W-1:0];
        CFG_MIN_TIMEOUT: min_timeout_q <= cfg_data_i[TIME_W-1:0];
        CFG_MAX_TIMEOUT: max_timeout_q <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign est_in.srtt        = srtt_q;
  assign est_in.spread      = spread_q;
  assign est_in.sample      = ev_q.rtt_us;
  assign est_in.min_timeout = min_timeout_q;
  assign est_in.max_timeout = max_timeout_q;

  rtts_estimator u_est (
    .est_i (est_in),
    .est_o (est_out)
  );

  assign wait_dbl = {wait_q, 1'b0};

  // event decode and state update
  always_comb begin
    srtt_d       = srtt_q;
    spread_d     = spread_q;
    wait_d       = wait_q;
    id_d         = id_q;
    att_d        = att_q;
    busy_d       = busy_q;
    resent_d     = resent_q;
    sent_cnt_d   = sent_cnt_q;
    resend_cnt_d = resend_cnt_q;
    fail_cnt_d   = fail_cnt_q;
    action       = ACT_IGNORE;
    case (rtts_mode_e'(ev_q.mode))
      MODE_START: begin
        // any message still in flight is dropped silently
        sent_cnt_d = sent_cnt_q + CNT_W'(1);
        resent_d   = 1'b0;
        id_d       = id_q + ID_W'(1);
        if (max_retries_q == '0) begin
          att_d      = '0;
          busy_d     = 1'b0;
          fail_cnt_d = fail_cnt_q + CNT_W'(1);
          action     = ACT_FAIL;
        end else begin
          att_d  = ATT_W'(1);
          busy_d = 1'b1;
          action = ACT_TRANSMIT;
        end
      end
      MODE_ACK: begin
        if (busy_q && ev_q.ack_from_target && (ev_q.ack_id == id_q)) begin
          srtt_d   = est_out.srtt;
          spread_d = est_out.spread;
          wait_d   = est_out.ack_wait;
          busy_d   = 1'b0;
          action   = ACT_DELIVER;
        end
      end
      default: begin
        // timeout and send error share the backoff path
        if (busy_q) begin
          if (wait_dbl >= {1'b0, max_timeout_q}) begin
            wait_d = max_timeout_q;
          end else begin
            wait_d = wait_dbl[TIME_W-1:0];
          end
          resend_cnt_d = resend_cnt_q + CNT_W'(1);
          resent_d     = 1'b1;
          if (att_q >= max_retries_q) begin
            fail_cnt_d = fail_cnt_q + CNT_W'(1);
            busy_d     = 1'b0;
            action     = ACT_FAIL;
          end else begin
            if (att_q != ATT_SAT) begin
              att_d = att_q + ATT_W'(1);
            end
            action = ACT_TRANSMIT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      srtt_q       <= '0;
      spread_q     <= RST_SPREAD;
      wait_q       <= RST_ACK_WAIT;
      id_q         <= '0;
      att_q        <= '0;
      busy_q       <= 1'b0;
      resent_q     <= 1'b0;
      sent_cnt_q   <= '0;
      resend_cnt_q <= '0;
      fail_cnt_q   <= '0;
    end else begin
      if (!in_stall_o) begin
        ev_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        srtt_q       <= srtt_d;
        spread_q     <= spread_d;
        wait_q       <= wait_d;
        id_q         <= id_d;
        att_q        <= att_d;
        busy_q       <= busy_d;
        resent_q     <= resent_d;
        sent_cnt_q   <= sent_cnt_d;
        resend_cnt_q <= resend_cnt_d;
        fail_cnt_q   <= fail_cnt_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ev_q <= in_data_i;
    end
    if (advance) begin
      out_q.action        <= action;
      out_q.message_id    <= id_d;
      out_q.wait_time     <= wait_d;
      out_q.attempt_count <= att_d;
      out_q.rtt_average   <= srtt_d;
      out_q.rtt_deviation <= spread_d;
      out_q.sent_total    <= sent_cnt_d;
      out_q.resent_total  <= resend_cnt_d;
      out_q.failed_total  <= fail_cnt_d;
      out_q.was_resent    <= resent_d;
    end
  end

endmodule

### sv/rtts_checker.sv
// Port-level checks of the retransmit sender, bound to the top level.
module rtts_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input rtts_pkg::rtts_out_t  out_data_o
);
  import rtts_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // a transmit always counts at least one attempt
  a_tx_attempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == ACT_TRANSMIT) |-> out_data_o.attempt_count != '0)
    else $error("transmit with zero attempts");

endmodule

bind rtt_retransmit_sender_unit rtts_checker u_rtts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
